// File: hw/rtl/cav_pkg.sv
package cav_pkg;

  // component width into a normalizer, and magnitude width (|c| < 2^63)
  localparam int CW    = 64;
  localparam int MAG_W = 63;
  // the largest scaled magnitude lands in [2^30, 2^31)
  localparam int MG_W  = 31;
  localparam int SQ_W  = 2 * MG_W;
  localparam int SUM_W = 64;
  // square root of the sum of squares, and its partial remainder
  localparam int ROOT_W = 32;
  localparam int REM_W  = 35;
  // output axis component width
  localparam int AXIS_W = 32;
  // left shift steps 32,16,8,4,2,1 bring the leading one to the top bit
  localparam int SHIFT_STEPS = 6;

  typedef logic [2:0][CW-1:0]     cvec_t;
  typedef logic [2:0][MAG_W-1:0]  magvec_t;
  typedef logic [2:0][MG_W-1:0]   mvec_t;
  typedef logic [2:0][AXIS_W-1:0] avec_t;

  typedef struct packed {
    logic       valid;
    logic       zero;
    logic [2:0] neg;
  } ctl_t;

  typedef struct packed {
    logic [SUM_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic [REM_W-1:0]  rem;
  } sqst_t;

endpackage

// File: hw/rtl/cav_sqrt_cell.sv
module cav_sqrt_cell import cav_pkg::*; #(
  parameter int SW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  ctl_t          ctl_in,
  input  sqst_t         st_in,
  input  logic [SW-1:0] side_in,
  output ctl_t          ctl_out,
  output sqst_t         st_out,
  output logic [SW-1:0] side_out
);

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;
  sqst_t            st_next;

  // one root bit per cell: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh       = {st_in.rem[REM_W-3:0], st_in.rad[SUM_W-1 -: 2]};
    trial        = {{(REM_W-ROOT_W-2){1'b0}}, st_in.root, 2'b01};
    fits         = (rem_sh >= trial);
    st_next.rad  = {st_in.rad[SUM_W-3:0], 2'b00};
    st_next.root = {st_in.root[ROOT_W-2:0], fits};
    st_next.rem  = fits ? (rem_sh - trial) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_out   <= st_next;
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/cav_div_cell.sv
module cav_div_cell import cav_pkg::*; #(
  parameter int QW = 31,
  parameter int SW = 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  ctl_t                      ctl_in,
  input  logic [ROOT_W-1:0]         n_in,
  input  logic [2:0][ROOT_W-1:0]    rem_in,
  input  logic [2:0][QW-1:0]        x_in,
  input  logic [SW-1:0]             side_in,
  output ctl_t                      ctl_out,
  output logic [ROOT_W-1:0]         n_out,
  output logic [2:0][ROOT_W-1:0]    rem_out,
  output logic [2:0][QW-1:0]        x_out,
  output logic [SW-1:0]             side_out
);

  // x holds the unused numerator bits on top, quotient bits fill from below
  logic [2:0][ROOT_W:0]   trial;
  logic [2:0][ROOT_W:0]   diff;
  logic [2:0]             fits;
  logic [2:0][ROOT_W-1:0] rem_next;
  logic [2:0][QW-1:0]     x_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      trial[k]    = {rem_in[k], x_in[k][QW-1]};
      fits[k]     = (trial[k] >= {1'b0, n_in});
      diff[k]     = trial[k] - {1'b0, n_in};
      rem_next[k] = fits[k] ? diff[k][ROOT_W-1:0] : trial[k][ROOT_W-1:0];
      x_next[k]   = {x_in[k][QW-2:0], fits[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (en) begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_out    <= n_in;
      rem_out  <= rem_next;
      x_out    <= x_next;
      side_out <= side_in;
    end
  end

endmodule

// File: hw/rtl/cav_norm.sv
module cav_norm import cav_pkg::*; #(
  parameter int OUT_FRAC_BITS = 30,
  parameter int PW            = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  cvec_t         c,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  output avec_t         r,
  output logic          zero,
  output logic [PW-1:0] pay_out
);

  localparam int QW = OUT_FRAC_BITS + 1;
  localparam int NW = OUT_FRAC_BITS + MG_W + 1;
  localparam int SW = 3 * MG_W + PW;
  localparam logic [QW-1:0] ONE_Q = {1'b1, {OUT_FRAC_BITS{1'b0}}};

  // magnitudes and signs
  cvec_t         c_neg;
  magvec_t       c_mag;
  ctl_t          a_ctl;
  magvec_t       a_mag;
  logic [PW-1:0] a_pay;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_neg[k] = -c[k];
      c_mag[k] = c[k][CW-1] ? c_neg[k][MAG_W-1:0] : c[k][MAG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctl <= '0;
    end else if (en) begin
      a_ctl <= '{valid: in_valid, zero: 1'b0,
                 neg: {c[2][CW-1], c[1][CW-1], c[0][CW-1]}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_mag <= c_mag;
      a_pay <= pay_in;
    end
  end

  // largest magnitude, then shift steps until its top bit is set
  logic [MAG_W-1:0] m01;
  logic [MAG_W-1:0] mx;
  ctl_t             sh_ctl [SHIFT_STEPS+1];
  logic [MAG_W-1:0] sh_m   [SHIFT_STEPS+1];
  magvec_t          sh_mag [SHIFT_STEPS+1];
  logic [PW-1:0]    sh_pay [SHIFT_STEPS+1];

  always_comb begin
    m01 = (a_mag[0] > a_mag[1]) ? a_mag[0] : a_mag[1];
    mx  = (m01 > a_mag[2]) ? m01 : a_mag[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sh_ctl[0] <= '0;
    end else if (en) begin
      sh_ctl[0] <= '{valid: a_ctl.valid, zero: (mx == '0), neg: a_ctl.neg};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sh_m[0]   <= mx;
      sh_mag[0] <= a_mag;
      sh_pay[0] <= a_pay;
    end
  end

  for (genvar s = 0; s < SHIFT_STEPS; s++) begin : g_shift
    localparam int K = 1 << (SHIFT_STEPS - 1 - s);
    logic hit;
    assign hit = (sh_m[s][MAG_W-1 -: K] == '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        sh_ctl[s+1] <= '0;
      end else if (en) begin
        sh_ctl[s+1] <= sh_ctl[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sh_m[s+1] <= hit ? (sh_m[s] << K) : sh_m[s];
        for (int k = 0; k < 3; k++) begin
          sh_mag[s+1][k] <= hit ? (sh_mag[s][k] << K) : sh_mag[s][k];
        end
        sh_pay[s+1] <= sh_pay[s];
      end
    end
  end

  // scaled magnitudes are the top bits, then their squares
  mvec_t                 mg;
  ctl_t                  q_ctl;
  mvec_t                 q_mg;
  logic [2:0][SQ_W-1:0]  q_sq;
  logic [PW-1:0]         q_pay;

  always_comb begin
    for (int k = 0; k < 3; k++) mg[k] = sh_mag[SHIFT_STEPS][k][MAG_W-1 -: MG_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_ctl <= '0;
    end else if (en) begin
      q_ctl <= sh_ctl[SHIFT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_mg <= mg;
      for (int k = 0; k < 3; k++) q_sq[k] <= mg[k] * mg[k];
      q_pay <= sh_pay[SHIFT_STEPS];
    end
  end

  // sum of squares
  ctl_t             s_ctl;
  mvec_t            s_mg;
  logic [SUM_W-1:0] s_sum;
  logic [PW-1:0]    s_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_ctl <= '0;
    end else if (en) begin
      s_ctl <= q_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_mg  <= q_mg;
      s_sum <= {{(SUM_W-SQ_W){1'b0}}, q_sq[0]} + {{(SUM_W-SQ_W){1'b0}}, q_sq[1]}
             + {{(SUM_W-SQ_W){1'b0}}, q_sq[2]};
      s_pay <= q_pay;
    end
  end

  // square root chain, one root bit per cell
  ctl_t          rt_ctl  [ROOT_W+1];
  sqst_t         rt_st   [ROOT_W+1];
  logic [SW-1:0] rt_side [ROOT_W+1];

  assign rt_ctl[0]  = s_ctl;
  assign rt_st[0]   = '{rad: s_sum, root: '0, rem: '0};
  assign rt_side[0] = {s_mg, s_pay};

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    cav_sqrt_cell #(.SW(SW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (rt_ctl[i]),
      .st_in    (rt_st[i]),
      .side_in  (rt_side[i]),
      .ctl_out  (rt_ctl[i+1]),
      .st_out   (rt_st[i+1]),
      .side_out (rt_side[i+1])
    );
  end

  // numerators mg * 2^f + n/2, split into starting remainder and low bits
  logic [ROOT_W-1:0]      n_root;
  mvec_t                  n_mg;
  logic [PW-1:0]          n_pay_in;
  logic [2:0][NW-1:0]     num;
  ctl_t                   dv_ctl [QW+1];
  logic [ROOT_W-1:0]      dv_n   [QW+1];
  logic [2:0][ROOT_W-1:0] dv_rem [QW+1];
  logic [2:0][QW-1:0]     dv_x   [QW+1];
  logic [PW-1:0]          dv_pay [QW+1];

  assign n_root           = rt_st[ROOT_W].root;
  assign {n_mg, n_pay_in} = rt_side[ROOT_W];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num[k] = {1'b0, n_mg[k], {OUT_FRAC_BITS{1'b0}}}
             + {{(OUT_FRAC_BITS+1){1'b0}}, n_root[ROOT_W-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_ctl[0] <= '0;
    end else if (en) begin
      dv_ctl[0] <= rt_ctl[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_n[0] <= n_root;
      for (int k = 0; k < 3; k++) begin
        dv_rem[0][k] <= {{(ROOT_W-MG_W){1'b0}}, num[k][NW-1:QW]};
        dv_x[0][k]   <= num[k][QW-1:0];
      end
      dv_pay[0] <= n_pay_in;
    end
  end

  // divide chain, one quotient bit per cell for all three lanes
  for (genvar j = 0; j < QW; j++) begin : g_div
    cav_div_cell #(.QW(QW), .SW(PW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (dv_ctl[j]),
      .n_in     (dv_n[j]),
      .rem_in   (dv_rem[j]),
      .x_in     (dv_x[j]),
      .side_in  (dv_pay[j]),
      .ctl_out  (dv_ctl[j+1]),
      .n_out    (dv_n[j+1]),
      .rem_out  (dv_rem[j+1]),
      .x_out    (dv_x[j+1]),
      .side_out (dv_pay[j+1])
    );
  end

  // clamp, sign, zero vector
  logic [2:0][QW-1:0] qc;
  avec_t              qe;
  avec_t              res;
  ctl_t               o_ctl;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc[k]  = (dv_x[QW][k] > ONE_Q) ? ONE_Q : dv_x[QW][k];
      qe[k]  = {{(AXIS_W-QW){1'b0}}, qc[k]};
      res[k] = dv_ctl[QW].zero ? '0 : (dv_ctl[QW].neg[k] ? -qe[k] : qe[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_ctl <= '0;
    end else if (en) begin
      o_ctl <= dv_ctl[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r       <= res;
      pay_out <= dv_pay[QW];
    end
  end

  assign out_valid = o_ctl.valid;
  assign zero      = o_ctl.zero;

endmodule

// File: hw/rtl/cav_cross.sv
module cav_cross import cav_pkg::*; #(
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  avec_t         a,
  input  avec_t         b,
  input  logic [PW-1:0] pay_in,
  output logic          out_valid,
  output cvec_t         c,
  output logic [PW-1:0] pay_out
);

  logic               p_valid;
  logic [5:0][CW-1:0] p;
  logic [PW-1:0]      p_pay;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      p_valid   <= in_valid;
      out_valid <= p_valid;
    end
  end

  // products are registered first, then the differences of the registered products
  always_ff @(posedge clk) begin
    if (en) begin
      p[0]    <= $signed(a[1]) * $signed(b[2]);
      p[1]    <= $signed(a[2]) * $signed(b[1]);
      p[2]    <= $signed(a[2]) * $signed(b[0]);
      p[3]    <= $signed(a[0]) * $signed(b[2]);
      p[4]    <= $signed(a[0]) * $signed(b[1]);
      p[5]    <= $signed(a[1]) * $signed(b[0]);
      p_pay   <= pay_in;
      c[0]    <= p[0] - p[1];
      c[1]    <= p[2] - p[3];
      c[2]    <= p[4] - p[5];
      pay_out <= p_pay;
    end
  end

endmodule

// File: hw/rtl/camera_basis_from_look_at_unit.sv
// throughput: one item per cycle; the whole pipeline holds while a result is stalled
// its bulk is three normalizers in series, each a 32-cell root chain
// followed by an (OUT_FRAC_BITS + 1)-cell divide chain
// reset: synchronous, clears every valid flag; data registers are not reset
module camera_basis_from_look_at_unit import cav_pkg::*; #(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] target_x,
  input  logic signed [31:0] target_y,
  input  logic signed [31:0] target_z,
  input  logic signed [31:0] upward_x,
  input  logic signed [31:0] upward_y,
  input  logic signed [31:0] upward_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] u_x,
  output logic signed [31:0] u_y,
  output logic signed [31:0] u_z,
  output logic signed [31:0] v_x,
  output logic signed [31:0] v_y,
  output logic signed [31:0] v_z,
  output logic signed [31:0] w_x,
  output logic signed [31:0] w_y,
  output logic signed [31:0] w_z,
  output logic               degenerate
);

  localparam int VW = 3 * AXIS_W;
  localparam logic [AXIS_W-1:0] ONE =
    {{(AXIS_W-OUT_FRAC_BITS-1){1'b0}}, 1'b1, {OUT_FRAC_BITS{1'b0}}};
  localparam logic [AXIS_W-1:0] NEG_ONE = -ONE;

  // global advance: every stage moves unless the output item is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // view difference eye - target, and the straight up or down cases
  logic        d_valid;
  cvec_t       d_c;
  avec_t       d_up;
  logic        d_spec;
  logic        d_down;
  logic [32:0] dx, dy, dz;

  always_comb begin
    dx = {eye_x[31], eye_x} - {target_x[31], target_x};
    dy = {eye_y[31], eye_y} - {target_y[31], target_y};
    dz = {eye_z[31], eye_z} - {target_z[31], target_z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_c[0] <= {{(CW-33){dx[32]}}, dx};
      d_c[1] <= {{(CW-33){dy[32]}}, dy};
      d_c[2] <= {{(CW-33){dz[32]}}, dz};
      d_up   <= {upward_z, upward_y, upward_x};
      d_spec <= (eye_x == target_x) && (eye_z == target_z);
      d_down <= (eye_y >= target_y);
    end
  end

  // w = normalize(eye - target); up vector and case flags ride along
  logic          nw_valid;
  avec_t         nw_r;
  logic          nw_zero;
  logic [VW+1:0] nw_pay;
  avec_t         nw_up;
  logic [1:0]    nw_flags;

  cav_norm #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .PW(VW + 2)) u_norm_w (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (d_valid),
    .c         (d_c),
    .pay_in    ({d_up, d_spec, d_down}),
    .out_valid (nw_valid),
    .r         (nw_r),
    .zero      (nw_zero),
    .pay_out   (nw_pay)
  );

  assign {nw_up, nw_flags} = nw_pay;

  // up x w
  logic          xu_valid;
  cvec_t         xu_c;
  logic [VW+1:0] xu_pay;

  cav_cross #(.PW(VW + 2)) u_cross_u (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (nw_valid),
    .a         (nw_up),
    .b         (nw_r),
    .pay_in    ({nw_r, nw_flags}),
    .out_valid (xu_valid),
    .c         (xu_c),
    .pay_out   (xu_pay)
  );

  // u = normalize(up x w); a zero cross product means up is along the view
  logic          nu_valid;
  avec_t         nu_r;
  logic          nu_zero;
  logic [VW+1:0] nu_pay;
  avec_t         nu_w;
  logic [1:0]    nu_flags;

  cav_norm #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .PW(VW + 2)) u_norm_u (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (xu_valid),
    .c         (xu_c),
    .pay_in    (xu_pay),
    .out_valid (nu_valid),
    .r         (nu_r),
    .zero      (nu_zero),
    .pay_out   (nu_pay)
  );

  assign {nu_w, nu_flags} = nu_pay;

  // w x u from the rounded unit vectors
  logic            xv_valid;
  cvec_t           xv_c;
  logic [2*VW+2:0] xv_pay;

  cav_cross #(.PW(2 * VW + 3)) u_cross_v (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (nu_valid),
    .a         (nu_w),
    .b         (nu_r),
    .pay_in    ({nu_w, nu_r, nu_zero, nu_flags}),
    .out_valid (xv_valid),
    .c         (xv_c),
    .pay_out   (xv_pay)
  );

  // v = normalize(w x u); zero when u is zero, and the output register also forces it to zero on that flag
  logic            nv_valid;
  avec_t           nv_r;
  logic            nv_zero;
  logic [2*VW+2:0] nv_pay;
  avec_t           nv_w;
  avec_t           nv_u;
  logic            nv_degen;
  logic            nv_spec;
  logic            nv_down;

  cav_norm #(.OUT_FRAC_BITS(OUT_FRAC_BITS), .PW(2 * VW + 3)) u_norm_v (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (xv_valid),
    .c         (xv_c),
    .pay_in    (xv_pay),
    .out_valid (nv_valid),
    .r         (nv_r),
    .zero      (nv_zero),
    .pay_out   (nv_pay)
  );

  assign {nv_w, nv_u, nv_degen, nv_spec, nv_down} = nv_pay;

  // output register: fixed bases when looking straight down or up
  logic  o_valid;
  avec_t o_u;
  avec_t o_v;
  avec_t o_w;
  logic  o_degen;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= nv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (nv_spec && nv_down) begin
        // looking down
        o_u     <= {ONE, {AXIS_W{1'b0}}, {AXIS_W{1'b0}}};
        o_v     <= {{AXIS_W{1'b0}}, {AXIS_W{1'b0}}, ONE};
        o_w     <= {{AXIS_W{1'b0}}, ONE, {AXIS_W{1'b0}}};
        o_degen <= 1'b0;
      end else if (nv_spec) begin
        // looking up
        o_u     <= {{AXIS_W{1'b0}}, {AXIS_W{1'b0}}, ONE};
        o_v     <= {ONE, {AXIS_W{1'b0}}, {AXIS_W{1'b0}}};
        o_w     <= {{AXIS_W{1'b0}}, NEG_ONE, {AXIS_W{1'b0}}};
        o_degen <= 1'b0;
      end else begin
        o_u     <= nv_u;
        o_v     <= nv_zero ? '0 : nv_r;
        o_w     <= nv_w;
        o_degen <= nv_degen;
      end
    end
  end

  assign out_valid  = o_valid;
  assign u_x        = o_u[0];
  assign u_y        = o_u[1];
  assign u_z        = o_u[2];
  assign v_x        = o_v[0];
  assign v_y        = o_v[1];
  assign v_z        = o_v[2];
  assign w_x        = o_w[0];
  assign w_y        = o_w[1];
  assign w_z        = o_w[2];
  assign degenerate = o_degen;

endmodule
